// ----- hdl/rbq_pkg.sv -----
// Shared types and constants of the resonator biquad filter.
// No dependencies; imported by every module of the block.
`default_nettype none
package rbq_pkg;

    localparam int ADC_W          = 12;
    localparam int CODE_W         = 8;
    localparam int COEF_W         = 18;
    localparam int COEF_FRAC_BITS = 16;
    localparam int ADC_DROP_BITS  = 4;
    localparam int OUT_FRAC       = 16;
    localparam int OUT_W          = 26;
    localparam int VAL_W          = OUT_W + 1;
    localparam int DIFF_W         = CODE_W + 1;
    localparam int FF_W           = COEF_W + DIFF_W;
    localparam int FB_W           = COEF_W + OUT_W;
    localparam int ACC_W          = FB_W + 2;
    localparam int CFG_ADDR_W     = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_GAIN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FB1  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FB2  = 2'd2;

    localparam logic signed [COEF_W-1:0] GAIN_RESET = 18'sd2323;
    localparam logic signed [COEF_W-1:0] FB1_RESET  = -18'sd100738;
    localparam logic signed [COEF_W-1:0] FB2_RESET  = 18'sd59146;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // DAC offset and byte limits, in output scale
    localparam logic signed [VAL_W-1:0] DAC_OFFSET_Q = VAL_W'(128 * (1 << OUT_FRAC));
    localparam logic signed [VAL_W-1:0] NEG_ONE_Q    = VAL_W'(-(1 << OUT_FRAC));
    localparam logic signed [VAL_W-1:0] FULL_Q       = VAL_W'(256 * (1 << OUT_FRAC));

    typedef struct packed {
        logic signed [COEF_W-1:0] gain;
        logic signed [COEF_W-1:0] fb1;
        logic signed [COEF_W-1:0] fb2;
    } coef_set_t;

    typedef struct packed {
        logic [CODE_W-1:0] dac_code;
        logic              clipped;
    } result_t;

endpackage
`default_nettype wire

// ----- hdl/resonator_biquad_filter.sv -----
// Top level of the resonator biquad filter: stream ports, input and
// result registers. Depends on rbq_pkg, rbq_cfg_regs and rbq_datapath.
//
// Takes one 12-bit converter sample per request, keeps its top byte, and
// returns one DAC byte with a clip flag per sample. A new request is
// accepted every cycle unless the receiver holds off results. A result
// passes the input register, then the result register. The result register
// lets the next sample be taken while a result waits. The rate of one
// sample per cycle is set by the filter recursion: the three coefficient
// products, their sum and the saturation are combinational between the
// history registers. The user must write the coefficients (Q2.16) through
// the cfg port only while idle; the block itself does not enforce this.
`default_nettype none
module resonator_biquad_filter (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [15:0]                     s_tdata,   // [11:0] adc_sample
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata,   // [7:0] dac_code
    output logic                                 m_tuser,   // [0] clipped
    input  wire logic                            cfg_we,
    input  wire logic [rbq_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [rbq_pkg::COEF_W-1:0]      cfg_data
);
    import rbq_pkg::*;

    coef_set_t         coefs;
    result_t           result;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [ADC_W-1:0]  in_sample_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_data_reg;
    logic              accept;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    rbq_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .coefs    (coefs)
    );

    rbq_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .sample (in_sample_reg),
        .coefs  (coefs),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_sample_reg <= s_tdata[ADC_W-1:0];
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg.dac_code;
    assign m_tuser  = out_data_reg.clipped;

endmodule
`default_nettype wire

// ----- hdl/rbq_cfg_regs.sv -----
// Coefficient register file of the resonator biquad filter.
// Depends on rbq_pkg.
`default_nettype none
module rbq_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [rbq_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [rbq_pkg::COEF_W-1:0]      cfg_data,
    output rbq_pkg::coef_set_t                   coefs
);
    import rbq_pkg::*;

    coef_set_t coef_reg;
    coef_set_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_GAIN: coef_next.gain = $signed(cfg_data);
                REG_FB1:  coef_next.fb1  = $signed(cfg_data);
                REG_FB2:  coef_next.fb2  = $signed(cfg_data);
                default:  coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.gain <= GAIN_RESET;
            coef_reg.fb1  <= FB1_RESET;
            coef_reg.fb2  <= FB2_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coefs = coef_reg;

endmodule
`default_nettype wire

// ----- hdl/rbq_datapath.sv -----
// Resonator recursion: input selection, three products, sum, saturation
// and DAC code, with the filter history registers. Depends on rbq_pkg.
`default_nettype none
module rbq_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [rbq_pkg::ADC_W-1:0]  sample,
    input  rbq_pkg::coef_set_t              coefs,
    output rbq_pkg::result_t                result
);
    import rbq_pkg::*;

    logic        [CODE_W-1:0] prev_in_1_reg;
    logic        [CODE_W-1:0] prev_in_2_reg;
    logic signed [OUT_W-1:0]  prev_out_1_reg;
    logic signed [OUT_W-1:0]  prev_out_2_reg;

    logic        [CODE_W-1:0] code;
    logic signed [DIFF_W-1:0] diff;
    logic signed [FF_W-1:0]   ff_prod;
    logic signed [FB_W-1:0]   fb1_prod;
    logic signed [FB_W-1:0]   fb2_prod;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_q16;
    logic signed [OUT_W-1:0]  y_next;
    logic                     out_sat;
    logic signed [VAL_W-1:0]  v;

    // offsets cancel in x - x[n-2]
    assign code = CODE_W'(sample >> ADC_DROP_BITS);
    assign diff = $signed({1'b0, code}) - $signed({1'b0, prev_in_2_reg});

    assign ff_prod  = coefs.gain * diff;
    assign fb1_prod = coefs.fb1 * prev_out_1_reg;
    assign fb2_prod = coefs.fb2 * prev_out_2_reg;

    assign acc = (ACC_W'(ff_prod) <<< OUT_FRAC) - ACC_W'(fb1_prod) - ACC_W'(fb2_prod);
    assign acc_q16 = acc >>> COEF_FRAC_BITS;

    always_comb
    begin
        out_sat = 1'b0;
        y_next  = OUT_W'(acc_q16);
        if (acc_q16 > ACC_W'(OUT_MAX))
        begin
            y_next  = OUT_MAX;
            out_sat = 1'b1;
        end
        else if (acc_q16 < ACC_W'(OUT_MIN))
        begin
            y_next  = OUT_MIN;
            out_sat = 1'b1;
        end
    end

    assign v = VAL_W'(y_next) + DAC_OFFSET_Q;

    // truncate toward zero, then clamp to a byte
    always_comb
    begin
        result.clipped  = out_sat;
        result.dac_code = v[OUT_FRAC+CODE_W-1:OUT_FRAC];
        if (v <= NEG_ONE_Q)
        begin
            result.dac_code = '0;
            result.clipped  = 1'b1;
        end
        else if (v < 0)
        begin
            result.dac_code = '0;
        end
        else if (v >= FULL_Q)
        begin
            result.dac_code = '1;
            result.clipped  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_in_1_reg  <= '0;
            prev_in_2_reg  <= '0;
            prev_out_1_reg <= '0;
            prev_out_2_reg <= '0;
        end
        else if (step)
        begin
            prev_in_2_reg  <= prev_in_1_reg;
            prev_in_1_reg  <= code;
            prev_out_2_reg <= prev_out_1_reg;
            prev_out_1_reg <= y_next;
        end
    end

endmodule
`default_nettype wire

// ----- sim/tb_resonator_biquad_filter.sv -----
// Self-checking testbench for resonator_biquad_filter: drives random and directed
// converter samples through the stream ports and checks every DAC byte and clip flag.
// Depends on rbq_pkg and the resonator_biquad_filter RTL.
`default_nettype none
module tb_resonator_biquad_filter;
    import rbq_pkg::*;

    localparam int                    DC_OFFSET      = 128;
    localparam int                    WATCHDOG_LIMIT = 2000;
    localparam int                    DRAIN_GAP      = 4;
    localparam logic [CFG_ADDR_W-1:0] REG_NONE       = 2'd3;

    // filter predictor and queue of expected DAC bytes
    class dac_scoreboard;
        logic signed [COEF_W-1:0] gain;
        logic signed [COEF_W-1:0] fb1;
        logic signed [COEF_W-1:0] fb2;
        logic [CODE_W-1:0]        in_d1;
        logic [CODE_W-1:0]        in_d2;
        logic signed [OUT_W-1:0]  out_d1;
        logic signed [OUT_W-1:0]  out_d2;
        result_t                  dac_expect_q[$];
        int                       mismatches;
        int                       samples;
        int                       clips;

        function new();
            gain       = GAIN_RESET;
            fb1        = FB1_RESET;
            fb2        = FB2_RESET;
            in_d1      = '0;
            in_d2      = '0;
            out_d1     = '0;
            out_d2     = '0;
            mismatches = 0;
            samples    = 0;
            clips      = 0;
        endfunction

        function void set_coef(input logic [CFG_ADDR_W-1:0] addr,
                               input logic [COEF_W-1:0] data);
            case (addr)
                REG_GAIN: gain = data;
                REG_FB1:  fb1  = data;
                REG_FB2:  fb2  = data;
                default:  ;
            endcase
        endfunction

        function void filter_sample(input logic [ADC_W-1:0] adc);
            logic [CODE_W-1:0] code;
            longint            x;
            longint            x2;
            longint            acc;
            longint            y;
            longint            v;
            longint            whole;
            result_t           r;
            code = CODE_W'(adc >> ADC_DROP_BITS);
            x    = longint'(code) - DC_OFFSET;
            x2   = longint'(in_d2) - DC_OFFSET;
            acc  = longint'(gain) * (x - x2) * (longint'(1) << OUT_FRAC);
            acc -= longint'(fb1) * longint'(out_d1);
            acc -= longint'(fb2) * longint'(out_d2);
            y    = acc >>> COEF_FRAC_BITS;
            r.clipped = 1'b0;
            if (y > longint'(OUT_MAX)) begin
                y = longint'(OUT_MAX);
                r.clipped = 1'b1;
            end else if (y < longint'(OUT_MIN)) begin
                y = longint'(OUT_MIN);
                r.clipped = 1'b1;
            end
            v     = y + (longint'(DC_OFFSET) << OUT_FRAC);
            whole = (v >= 0) ? (v >>> OUT_FRAC) : -((-v) >>> OUT_FRAC);
            if (whole < 0) begin
                r.dac_code = '0;
                r.clipped  = 1'b1;
            end else if (whole > 255) begin
                r.dac_code = '1;
                r.clipped  = 1'b1;
            end else begin
                r.dac_code = CODE_W'(whole);
            end
            in_d2  = in_d1;
            in_d1  = code;
            out_d2 = out_d1;
            out_d1 = OUT_W'(y);
            samples++;
            if (r.clipped)
                clips++;
            dac_expect_q.push_back(r);
        endfunction

        function void check_result(input logic [CODE_W-1:0] code, input logic clip);
            result_t exp_r;
            if (dac_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: dac_code=%0d clipped=%0b", code, clip);
                return;
            end
            exp_r = dac_expect_q.pop_front();
            if (code !== exp_r.dac_code || clip !== exp_r.clipped) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: dac_code exp %0d got %0d, clipped exp %0b got %0b",
                             exp_r.dac_code, code, exp_r.clipped, clip);
            end
        endfunction

        function int pending();
            return dac_expect_q.size();
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata  = '0;     // [11:0] adc_sample
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;           // [7:0] dac_code
    logic                  m_tuser;           // [0] clipped
    logic                  cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [COEF_W-1:0]     cfg_data = '0;

    dac_scoreboard sb = new();
    bit            tx_idle  = 1'b1;
    bit            rx_stall = 1'b1;
    int            walk     = 2048;
    int            settings = 1;
    int            idle_cycles = 0;

    resonator_biquad_filter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sb.filter_sample(s_tdata[ADC_W-1:0]);
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        if (cfg_we)
            sb.set_coef(cfg_addr, cfg_data);
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("[resonator_biquad_filter] ERROR");
                $finish;
            end
        end
    end

    // receiver back-pressure
    initial
    begin
        forever begin
            @(posedge clk);
            if (rst_n && rx_stall && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_sample(input logic [ADC_W-1:0] adc);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, adc};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // queue is sampled between edges, after the scoreboard has seen the edge
    task automatic drain();
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [COEF_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
    endtask

    function automatic logic [ADC_W-1:0] next_sample();
        case ($urandom_range(0, 3))
            0: return ADC_W'($urandom_range(0, 4095));
            3: return ($urandom_range(0, 1) == 1) ? '1 : '0;
            default:
            begin
                walk = walk + $urandom_range(0, 400) - 200;
                if (walk < 0)
                    walk = 0;
                if (walk > 4095)
                    walk = 4095;
                return ADC_W'(walk);
            end
        endcase
    endfunction

    task automatic run_phase(input int g, input int f1, input int f2, input int count);
        drain();
        cfg_write(REG_GAIN, COEF_W'(g));
        cfg_write(REG_FB1, COEF_W'(f1));
        cfg_write(REG_FB2, COEF_W'(f2));
        cfg_we <= 1'b0;
        settings++;
        for (int i = 0; i < count; i++) begin
            send_sample(next_sample());
            // hold the sender until the block has emptied
            if (i == count / 2) begin
                s_tvalid <= 1'b0;
                drain();
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        logic [ADC_W-1:0] directed [0:23] = '{
            12'h000, 12'hFFF, 12'h7FF, 12'h800, 12'h80F, 12'h7F0, 12'h00F, 12'hFF0,
            12'h800, 12'h800, 12'hFFF, 12'h800, 12'h800, 12'h800, 12'h000, 12'h000,
            12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hA5A, 12'h5A5, 12'h800, 12'h800
        };
        int a2;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients
        foreach (directed[i])
            send_sample(directed[i]);
        for (int i = 0; i < 300; i++) begin
            send_sample(next_sample());
            if (i == 150) begin
                s_tvalid <= 1'b0;
                drain();
            end
        end
        s_tvalid <= 1'b0;

        // write to an unused index must leave the coefficients alone
        drain();
        cfg_write(REG_NONE, COEF_W'($urandom_range(0, 262143)));
        cfg_we <= 1'b0;
        for (int i = 0; i < 100; i++)
            send_sample(next_sample());
        s_tvalid <= 1'b0;

        run_phase(131071, 0, 0, 100);
        run_phase(-131072, -131072, 131071, 100);
        run_phase(131071, 131071, -131072, 60);
        run_phase(0, 0, 0, 50);
        run_phase($urandom_range(0, 262143), $urandom_range(0, 262143),
                  $urandom_range(0, 262143), 120);
        for (int k = 0; k < 2; k++) begin
            a2 = $urandom_range(20000, 64000);
            run_phase($urandom_range(0, 20000) - 10000,
                      $urandom_range(0, 2 * (a2 + 64000)) - (a2 + 64000), a2, 150);
        end

        // closing stretch at full rate
        drain();
        tx_idle  = 1'b0;
        rx_stall = 1'b0;
        run_phase(GAIN_RESET, FB1_RESET, FB2_RESET, 300);

        drain();
        $display("%0d samples over %0d coefficient settings, %0d results clipped,",
                 sb.samples, settings, sb.clips);
        $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[resonator_biquad_filter] OK");
        else
            $display("[resonator_biquad_filter] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
